FILE: sv/vtsc_pkg.sv
// ----------------------------------------------------------------------------
// vtsc_pkg
// Types and constants shared by the vlan tag strip classifier modules.
// ----------------------------------------------------------------------------
package vtsc_pkg;

   localparam int unsigned HDR_DEPTH = 18;
   localparam int unsigned HDR_IDX_W = 5;

   localparam logic [15:0] TPID_8021Q = 16'h8100;

   // header byte positions
   localparam logic [HDR_IDX_W-1:0] IDX_ETYPE_HI = 5'd12;
   localparam logic [HDR_IDX_W-1:0] IDX_ETYPE_LO = 5'd13;
   localparam logic [HDR_IDX_W-1:0] IDX_TCI_HI   = 5'd14;
   localparam logic [HDR_IDX_W-1:0] IDX_TCI_LO   = 5'd15;
   localparam logic [HDR_IDX_W-1:0] IDX_AFTER_TAG = 5'd16;
   localparam logic [HDR_IDX_W-1:0] IDX_HDR_LAST = 5'd17;
   localparam logic [HDR_IDX_W-1:0] IDX_BEFORE_TAG = 5'd11;

   // register indexes
   localparam logic CSR_ACCEPT_MODE = 1'b0;
   localparam logic CSR_PORT_VID    = 1'b1;

   // accept_mode codes
   localparam logic [1:0] MODE_UNTAGGED_PRIO = 2'd0;
   localparam logic [1:0] MODE_TAGGED_ONLY   = 2'd1;
   localparam logic [1:0] MODE_ACCEPT_ALL    = 2'd2;

   localparam logic [11:0] PORT_VID_RESET = 12'd1;

   localparam int unsigned Q_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_DROP,
      CMD_BURST
   } cmd_kind_type;

   // one command from the classifier to the emitter
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic [11:0]  vid;
      logic         strip;     // burst skips the four tag bytes
      logic         full_hdr;  // burst covers 18 bytes, else 14
   } cmd_type;

   // emitter status back to the classifier
   typedef struct packed {
      logic                 burst_done;
      logic [HDR_IDX_W-1:0] rd_idx;
   } emit_stat_type;

endpackage

FILE: sv/vtsc_if.sv
// ----------------------------------------------------------------------------
// vtsc_if
// Valid/ready channels for frame bytes in and classified results out.
// ----------------------------------------------------------------------------
interface vtsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface vtsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_last;
   logic [11:0] frame_vid;
   logic        dropped;

   modport source (output valid, output out_byte, output out_last, output frame_vid,
                   output dropped, input ready);
   modport sink (input valid, input out_byte, input out_last, input frame_vid,
                 input dropped, output ready);
endinterface

FILE: sv/vtsc_fifo.sv
// ----------------------------------------------------------------------------
// vtsc_fifo
// Short command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module vtsc_fifo
   import vtsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

   cmd_type              entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = (count_ff == CNT_W'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(Q_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop && !empty) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/vtsc_classify.sv
// ----------------------------------------------------------------------------
// vtsc_classify
// Front end: takes frame bytes, holds the header and decides each frame.
// ----------------------------------------------------------------------------
module vtsc_classify
   import vtsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   vtsc_req_if.sink      req_chan,
   input  logic          csr_write_en,
   input  logic          csr_index,
   input  logic [11:0]   csr_wdata,
   output logic          push,
   output cmd_type       push_cmd,
   input  logic          q_full,
   input  emit_stat_type emit_stat,
   output logic [7:0]    hdr_rd_data
);

   typedef enum logic [1:0] {
      PH_COLLECT,
      PH_PASS,
      PH_DROP
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   count_ff, count_in;
   logic [11:0]            held_vid_ff, held_vid_in;
   logic                   busy_ff, busy_in;
   logic [1:0]             mode_ff;
   logic [11:0]            port_vid_ff;
   logic [7:0]             hdr_ff [HDR_DEPTH];

   logic                   accept;
   logic [HDR_IDX_W-1:0]   count_nxt;
   logic [7:0]             etype_lo;
   logic                   is_tagged;
   logic [11:0]            tag_vid;

   assign req_chan.ready = !q_full && !busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign hdr_rd_data    = hdr_ff[emit_stat.rd_idx];

   assign count_nxt = count_ff + 1'b1;
   // the low ethertype byte is still on the input when the decision falls on it
   assign etype_lo  = (count_ff == IDX_ETYPE_LO) ? req_chan.in_byte : hdr_ff[IDX_ETYPE_LO];
   assign is_tagged = ({hdr_ff[IDX_ETYPE_HI], etype_lo} == TPID_8021Q);
   assign tag_vid   = {hdr_ff[IDX_TCI_HI][3:0], hdr_ff[IDX_TCI_LO]};

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      held_vid_in = held_vid_ff;
      busy_in     = busy_ff;
      push        = 1'b0;
      push_cmd    = '{kind: CMD_BYTE, data: req_chan.in_byte, last: req_chan.in_last,
                      vid: held_vid_ff, strip: 1'b0, full_hdr: 1'b0};

      if (emit_stat.burst_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         case (phase_ff)
            PH_PASS: begin
               push = 1'b1;
               if (req_chan.in_last) begin
                  phase_in = PH_COLLECT;
                  count_in = '0;
               end
            end
            PH_DROP: begin
               if (req_chan.in_last) begin
                  push          = 1'b1;
                  push_cmd.kind = CMD_DROP;
                  phase_in      = PH_COLLECT;
                  count_in      = '0;
               end
            end
            default: begin
               count_in = count_nxt;
               if (count_nxt < HDR_IDX_W'(IDX_ETYPE_LO + 1'b1) ||
                   (is_tagged && count_nxt < HDR_IDX_W'(HDR_DEPTH))) begin
                  // still short of a decision
                  if (req_chan.in_last) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_DROP;
                     count_in      = '0;
                  end
               end else if ((!is_tagged && mode_ff == MODE_TAGGED_ONLY) ||
                            (is_tagged && mode_ff == MODE_UNTAGGED_PRIO &&
                             tag_vid != '0)) begin
                  count_in = '0;
                  if (req_chan.in_last) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_DROP;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end else begin
                  push              = 1'b1;
                  busy_in           = 1'b1;
                  count_in          = '0;
                  push_cmd.kind     = CMD_BURST;
                  push_cmd.full_hdr = is_tagged;
                  push_cmd.strip    = is_tagged && (tag_vid != '0);
                  push_cmd.vid      = (is_tagged && tag_vid != '0) ? tag_vid : port_vid_ff;
                  held_vid_in       = push_cmd.vid;
                  phase_in          = req_chan.in_last ? PH_COLLECT : PH_PASS;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COLLECT;
         count_ff    <= '0;
         held_vid_ff <= '0;
         busy_ff     <= 1'b0;
         mode_ff     <= MODE_ACCEPT_ALL;
         port_vid_ff <= PORT_VID_RESET;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         held_vid_ff <= held_vid_in;
         busy_ff     <= busy_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_ACCEPT_MODE: mode_ff     <= csr_wdata[1:0];
               CSR_PORT_VID:    port_vid_ff <= csr_wdata;
               default:         mode_ff     <= mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_COLLECT && count_ff < HDR_IDX_W'(HDR_DEPTH)) begin
         hdr_ff[count_ff] <= req_chan.in_byte;
      end
   end

endmodule

FILE: sv/vtsc_emit.sv
// ----------------------------------------------------------------------------
// vtsc_emit
// Back end: carries out queued commands and drives the result register.
// ----------------------------------------------------------------------------
module vtsc_emit
   import vtsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  cmd_type       head_cmd,
   output logic          pop,
   output emit_stat_type emit_stat,
   input  logic [7:0]    hdr_rd_data,
   vtsc_rsp_if.source    rsp_chan
);

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   state_type            state_ff, state_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 strip_ff, strip_in;
   logic                 full_ff, full_in;
   logic                 last_ff, last_in;
   logic [11:0]          vid_ff, vid_in;

   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 olast_ff, olast_in;
   logic [11:0]          ovid_ff, ovid_in;
   logic                 drop_ff, drop_in;

   logic                 advance;
   logic                 burst_done;
   logic [HDR_IDX_W-1:0] end_idx;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign end_idx  = full_ff ? IDX_HDR_LAST : IDX_ETYPE_LO;

   assign emit_stat = '{burst_done: burst_done,
                        rd_idx:     (state_ff == ST_BURST) ? idx_ff : '0};

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.out_last  = olast_ff;
   assign rsp_chan.frame_vid = ovid_ff;
   assign rsp_chan.dropped   = drop_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      strip_in   = strip_ff;
      full_in    = full_ff;
      last_in    = last_ff;
      vid_in     = vid_ff;
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      olast_in   = olast_ff;
      ovid_in    = ovid_ff;
      drop_in    = drop_ff;
      pop        = 1'b0;
      burst_done = 1'b0;

      if (advance) begin
         valid_in = 1'b0;
         if (state_ff == ST_BURST) begin
            valid_in = 1'b1;
            byte_in  = hdr_rd_data;
            ovid_in  = vid_ff;
            drop_in  = 1'b0;
            olast_in = last_ff && (idx_ff == end_idx);
            if (idx_ff == end_idx) begin
               state_in   = ST_IDLE;
               burst_done = 1'b1;
            end else if (strip_ff && idx_ff == IDX_BEFORE_TAG) begin
               idx_in = IDX_AFTER_TAG;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else if (!q_empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            case (head_cmd.kind)
               CMD_BYTE: begin
                  byte_in  = head_cmd.data;
                  olast_in = head_cmd.last;
                  ovid_in  = head_cmd.vid;
                  drop_in  = 1'b0;
               end
               CMD_BURST: begin
                  // header byte 0 goes out now, the rest one per cycle while rsp_chan is not stalled
                  byte_in  = hdr_rd_data;
                  olast_in = 1'b0;
                  ovid_in  = head_cmd.vid;
                  drop_in  = 1'b0;
                  state_in = ST_BURST;
                  idx_in   = HDR_IDX_W'(1);
                  strip_in = head_cmd.strip;
                  full_in  = head_cmd.full_hdr;
                  last_in  = head_cmd.last;
                  vid_in   = head_cmd.vid;
               end
               default: begin
                  byte_in  = '0;
                  olast_in = 1'b1;
                  ovid_in  = '0;
                  drop_in  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff   <= idx_in;
      strip_ff <= strip_in;
      full_ff  <= full_in;
      last_ff  <= last_in;
      vid_ff   <= vid_in;
      byte_ff  <= byte_in;
      olast_ff <= olast_in;
      ovid_ff  <= ovid_in;
      drop_ff  <= drop_in;
   end

endmodule

FILE: sv/vlan_tag_strip_classifier_top.sv
// ----------------------------------------------------------------------------
// vlan_tag_strip_classifier_top
// 802.1Q tag strip and VLAN classification on an ingress byte stream.
// ----------------------------------------------------------------------------
// Frame bytes enter on req_chan one per transaction and leave on rsp_chan.
// The first 14 header bytes (18 for a tagged frame) are held until the frame
// is decided; the held header of an accepted frame is then sent out one byte
// per cycle while rsp_chan is not stalled, from the single header read port,
// and no new byte is taken until the header burst has gone out. After the
// decision the remaining bytes pass through one by one. A dropped frame gives
// one drop result at its last byte. The user must write accept_mode (index 0)
// and port_vid (index 1) on the csr_ port only while no frame is in flight;
// the block itself does not enforce this.
module vlan_tag_strip_classifier_top
   import vtsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vtsc_req_if.sink    req_chan,
   vtsc_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   logic          push;
   cmd_type       push_cmd;
   logic          q_full;
   logic          q_empty;
   logic          pop;
   cmd_type       head_cmd;
   emit_stat_type emit_stat;
   logic [7:0]    hdr_rd_data;

   vtsc_classify u_classify (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .push_cmd     (push_cmd),
      .q_full       (q_full),
      .emit_stat    (emit_stat),
      .hdr_rd_data  (hdr_rd_data)
   );

   vtsc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   vtsc_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .emit_stat   (emit_stat),
      .hdr_rd_data (hdr_rd_data),
      .rsp_chan    (rsp_chan)
   );

endmodule
